// ===== design/tdl_pkg.sv =====
// Package for the table-driven lexer: item, result and command types,
// field widths, op and result codes, queue depths.
// No dependencies.
package tdl_pkg;

	localparam int STATE_W     = 6;
	localparam int SYM_W       = 5;
	localparam int CAT_W       = 4;
	localparam int LEN_W       = 16;
	localparam int OP_W        = 3;
	localparam int MAX_STATES  = 2 ** STATE_W;
	localparam int MAX_SYMBOLS = 2 ** SYM_W;
	localparam int CQ_DEPTH    = 4;
	localparam int RQ_DEPTH    = 4;

	localparam logic [STATE_W-1:0] FLUSH_RESET = 6'd63;

	localparam logic [OP_W-1:0] OP_LOAD_CLASS = 3'd0;
	localparam logic [OP_W-1:0] OP_LOAD_TRANS = 3'd1;
	localparam logic [OP_W-1:0] OP_LOAD_CAT   = 3'd2;
	localparam logic [OP_W-1:0] OP_SCAN       = 3'd3;
	localparam logic [OP_W-1:0] OP_END        = 3'd4;

	localparam logic KIND_TOKEN = 1'b0;
	localparam logic KIND_ERROR = 1'b1;

	typedef struct packed {
		logic [OP_W-1:0]    op;
		logic [7:0]         char_code;
		logic [SYM_W-1:0]   symbol_index;
		logic               symbol_valid;
		logic [STATE_W-1:0] state_index;
		logic [STATE_W-1:0] target_state;
		logic [CAT_W-1:0]   category_code;
		logic               category_valid;
	} item_t;

	typedef struct packed {
		logic               kind;
		logic [CAT_W-1:0]   token_category;
		logic               token_has_category;
		logic [LEN_W-1:0]   lexeme_length;
		logic [7:0]         error_byte;
		logic               last;
	} result_t;

	typedef enum logic [2:0] {
		CMD_LOAD_TRANS,
		CMD_LOAD_CAT,
		CMD_SCAN,
		CMD_BAD,
		CMD_END
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t          kind;
		logic [7:0]         chr;
		logic [SYM_W-1:0]   sym;
		logic [STATE_W-1:0] st;
		logic [STATE_W-1:0] tgt;
		logic [CAT_W-1:0]   cat;
		logic               cat_ok;
	} cmd_t;

	typedef struct packed {
		logic [1:0] n;
		result_t    r0;
		result_t    r1;
	} res_push_t;

endpackage

// ===== design/table_driven_lexer.sv =====
// Top level of the table-driven lexer: front end, command queue,
// back end and result queue. Depends on tdl_pkg and the tdl_* modules.
//
//   channel   handshake              payload
//   input     push / full            item   (item_t)
//   result    pop / empty            result (result_t)
//   config    cfg_valid / cfg_ready  cfg_data (flush state)
//
// The front end takes one item a cycle while the command queue has room.
// A scan byte is handled in the back end by a transition read, then
// evaluation; a byte that reaches the flush state adds a reread from
// state 0. Loads are written in the issue state; class loads never leave the front.
// Reset is immediate: class and category valid bits clear at once, no sweep.
// Under two free result slots stall only the back end; the front fills the queue.
module table_driven_lexer
	import tdl_pkg::*;
#(
	parameter int NUM_STATES     = 64,
	parameter int NUM_SYMBOLS    = 32,
	parameter int NUM_CATEGORIES = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               full,
	input  item_t              item,
	output logic               empty,
	input  logic               pop,
	output result_t            result,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [STATE_W-1:0] cfg_data
);

	logic      cq_full;
	logic      cq_push;
	cmd_t      cq_cmd;
	logic      cq_pop;
	logic      head_vld;
	cmd_t      head;
	logic      room2;
	res_push_t rpush;

	tdl_front #(
		.NUM_STATES     (NUM_STATES),
		.NUM_SYMBOLS    (NUM_SYMBOLS),
		.NUM_CATEGORIES (NUM_CATEGORIES)
	) u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.full    (full),
		.item    (item),
		.cq_full (cq_full),
		.cq_push (cq_push),
		.cq_cmd  (cq_cmd)
	);

	tdl_cq u_cq (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (cq_push),
		.cmd      (cq_cmd),
		.full     (cq_full),
		.pop      (cq_pop),
		.head_vld (head_vld),
		.head     (head)
	);

	tdl_back #(
		.NUM_STATES  (NUM_STATES),
		.NUM_SYMBOLS (NUM_SYMBOLS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.head_vld  (head_vld),
		.head      (head),
		.pop       (cq_pop),
		.room2     (room2),
		.rpush     (rpush)
	);

	tdl_rq u_rq (
		.clk    (clk),
		.arst_n (arst_n),
		.rpush  (rpush),
		.room2  (room2),
		.empty  (empty),
		.pop    (pop),
		.result (result)
	);

endmodule

// ===== design/tdl_front.sv =====
// Front end of the lexer: accepts items, owns the byte class map,
// classifies transition, category, scan and end items into commands for the back end.
// Depends on tdl_pkg.
module tdl_front
	import tdl_pkg::*;
#(
	parameter int NUM_STATES     = 64,
	parameter int NUM_SYMBOLS    = 32,
	parameter int NUM_CATEGORIES = 16
) (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push,
	output logic  full,
	input  item_t item,
	input  logic  cq_full,
	output logic  cq_push,
	output cmd_t  cq_cmd
);

	logic             vld_s1;
	item_t            item_s1;
	logic [SYM_W-1:0] csym_s1;
	logic             chit_s1;

	logic [SYM_W-1:0] cmap_q [256];
	logic [255:0]     cvld_q;

	logic accept;
	logic class_we;
	logic need;
	logic adv;

	assign accept   = push && !full;
	assign class_we = accept && (item.op == OP_LOAD_CLASS)
		&& (int'(item.symbol_index) < NUM_SYMBOLS);

	always_comb begin
		cq_cmd        = '0;
		cq_cmd.chr    = item_s1.char_code;
		cq_cmd.sym    = item_s1.symbol_index;
		cq_cmd.st     = item_s1.state_index;
		cq_cmd.tgt    = item_s1.target_state;
		cq_cmd.cat    = item_s1.category_code;
		cq_cmd.cat_ok = item_s1.category_valid;
		need          = 1'b0;
		case (item_s1.op)
			OP_LOAD_TRANS: begin
				cq_cmd.kind = CMD_LOAD_TRANS;
				need = (int'(item_s1.state_index) < NUM_STATES)
					&& (int'(item_s1.symbol_index) < NUM_SYMBOLS)
					&& (int'(item_s1.target_state) < NUM_STATES);
			end
			OP_LOAD_CAT: begin
				cq_cmd.kind = CMD_LOAD_CAT;
				need = (int'(item_s1.state_index) < NUM_STATES)
					&& (int'(item_s1.category_code) < NUM_CATEGORIES);
			end
			OP_SCAN: begin
				cq_cmd.kind = chit_s1 ? CMD_SCAN : CMD_BAD;
				cq_cmd.sym  = csym_s1;
				need = 1'b1;
			end
			OP_END: begin
				cq_cmd.kind = CMD_END;
				need = 1'b1;
			end
			default: need = 1'b0;
		endcase
	end

	assign full    = vld_s1 && need && cq_full;
	assign adv     = vld_s1 && !(need && cq_full);
	assign cq_push = vld_s1 && need && !cq_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			cvld_q <= '0;
		end else begin
			if (accept) begin
				vld_s1 <= 1'b1;
			end else if (adv) begin
				vld_s1 <= 1'b0;
			end
			if (class_we) begin
				cvld_q[item.char_code] <= item.symbol_valid;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= item;
			csym_s1 <= cmap_q[item.char_code];
			chit_s1 <= cvld_q[item.char_code];
		end
		if (class_we) begin
			cmap_q[item.char_code] <= item.symbol_index;
		end
	end

endmodule

// ===== design/tdl_cq.sv =====
// Command queue between the lexer front and back ends.
// Depends on tdl_pkg.
module tdl_cq
	import tdl_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t cmd,
	output logic full,
	input  logic pop,
	output logic head_vld,
	output cmd_t head
);

	localparam int PW = $clog2(CQ_DEPTH);

	cmd_t          mem_q [CQ_DEPTH];
	logic [PW-1:0] wr_q;
	logic [PW-1:0] rd_q;
	logic [PW:0]   cnt_q;
	logic          do_push;
	logic          do_pop;

	assign full     = (cnt_q == (PW+1)'(CQ_DEPTH));
	assign head_vld = (cnt_q != '0);
	assign head     = mem_q[rd_q];
	assign do_push  = push && !full;
	assign do_pop   = pop && head_vld;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= wr_q + PW'(1);
			end
			if (do_pop) begin
				rd_q <= rd_q + PW'(1);
			end
			cnt_q <= cnt_q + (PW+1)'(do_push) - (PW+1)'(do_pop);
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_q] <= cmd;
		end
	end

endmodule

// ===== design/tdl_back.sv =====
// Back end of the lexer: transition and category tables, DFA state,
// token and error generation.
// Depends on tdl_pkg.
module tdl_back
	import tdl_pkg::*;
#(
	parameter int NUM_STATES  = 64,
	parameter int NUM_SYMBOLS = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [STATE_W-1:0] cfg_data,
	input  logic               head_vld,
	input  cmd_t               head,
	output logic               pop,
	input  logic               room2,
	output res_push_t          rpush
);

	localparam int C_D   = (NUM_STATES < MAX_STATES) ? NUM_STATES : MAX_STATES;
	localparam int S_D   = (NUM_SYMBOLS < MAX_SYMBOLS) ? NUM_SYMBOLS : MAX_SYMBOLS;
	localparam int T_D   = C_D * S_D;
	localparam int CA_W  = $clog2(C_D);
	localparam int TA_W  = (T_D > 1) ? $clog2(T_D) : 1;

	typedef enum logic [1:0] {
		ST_ISSUE,
		ST_EVAL,
		ST_FLUSH
	} state_t;

	state_t             state_q;
	logic [STATE_W-1:0] flush_q;
	logic [STATE_W-1:0] cur_q;
	logic               seen_q;
	logic [CAT_W-1:0]   pend_q;
	logic [LEN_W-1:0]   len_q;
	logic               cat_pend_q;

	logic [STATE_W-1:0] tmem_q [T_D];
	logic [STATE_W-1:0] trd_q;
	logic [CAT_W-1:0]   cmem_q [C_D];
	logic [C_D-1:0]     cvl_q;
	logic [CAT_W-1:0]   crd_q;
	logic               chit_q;

	logic               t_re;
	logic               t_we;
	logic [TA_W-1:0]    t_raddr;
	logic [TA_W-1:0]    t_waddr;
	logic               c_re;
	logic               c_we;
	logic [CA_W-1:0]    c_raddr;
	logic [CA_W-1:0]    c_waddr;

	logic               eff_hit;
	logic               eff_seen;
	logic [CAT_W-1:0]   eff_pend;
	logic               f_seen;
	logic [CAT_W-1:0]   f_pend;
	logic [LEN_W-1:0]   len_inc;

	function automatic logic [TA_W-1:0] taddr(logic [STATE_W-1:0] st, logic [SYM_W-1:0] sy);
		return TA_W'(int'(st) * S_D + int'(sy));
	endfunction

	function automatic result_t tok(logic h, logic [CAT_W-1:0] c, logic [LEN_W-1:0] l,
		logic lst);
		result_t r;
		r                    = '0;
		r.kind               = KIND_TOKEN;
		r.token_category     = h ? c : '0;
		r.token_has_category = h;
		r.lexeme_length      = l;
		r.last               = lst;
		return r;
	endfunction

	function automatic result_t err(logic [7:0] b);
		result_t r;
		r            = '0;
		r.kind       = KIND_ERROR;
		r.error_byte = b;
		r.last       = 1'b1;
		return r;
	endfunction

	assign cfg_ready = 1'b1;

	assign eff_hit  = cat_pend_q && chit_q;
	assign eff_seen = seen_q || eff_hit;
	assign eff_pend = eff_hit ? crd_q : pend_q;
	assign f_seen   = seen_q || chit_q;
	assign f_pend   = chit_q ? crd_q : pend_q;
	assign len_inc  = (len_q == '1) ? len_q : len_q + LEN_W'(1);

	assign t_waddr  = taddr(head.st, head.sym);
	assign c_waddr  = CA_W'(head.st);

	always_comb begin
		pop     = 1'b0;
		t_re    = 1'b0;
		t_we    = 1'b0;
		t_raddr = taddr(cur_q, head.sym);
		c_re    = 1'b0;
		c_we    = 1'b0;
		c_raddr = CA_W'(trd_q);
		rpush   = '0;
		case (state_q)
			ST_ISSUE: begin
				if (head_vld) begin
					case (head.kind)
						CMD_LOAD_TRANS: begin
							t_we = 1'b1;
							pop  = 1'b1;
						end
						CMD_LOAD_CAT: begin
							c_we = 1'b1;
							pop  = 1'b1;
						end
						CMD_SCAN: t_re = 1'b1;
						CMD_BAD: begin
							if (room2) begin
								pop = 1'b1;
								if (eff_seen) begin
									rpush.n  = 2'd2;
									rpush.r0 = tok(1'b1, eff_pend, len_q, 1'b0);
									rpush.r1 = err(head.chr);
								end else begin
									rpush.n  = 2'd1;
									rpush.r0 = err(head.chr);
								end
							end
						end
						CMD_END: begin
							if (room2) begin
								pop = 1'b1;
								if (eff_seen) begin
									rpush.n  = 2'd1;
									rpush.r0 = tok(1'b1, eff_pend, len_q, 1'b1);
								end
							end
						end
						default: pop = 1'b0;
					endcase
				end
			end
			ST_EVAL: begin
				c_re = 1'b1;
				if (trd_q == flush_q) begin
					t_re    = 1'b1;
					t_raddr = taddr('0, head.sym);
				end else begin
					pop = 1'b1;
				end
			end
			ST_FLUSH: begin
				if (room2) begin
					pop  = 1'b1;
					c_re = 1'b1;
					if (trd_q == flush_q) begin
						rpush.n  = 2'd2;
						rpush.r0 = tok(f_seen, f_pend, len_q, 1'b0);
						rpush.r1 = err(head.chr);
					end else begin
						rpush.n  = 2'd1;
						rpush.r0 = tok(f_seen, f_pend, len_q, 1'b1);
					end
				end
			end
			default: pop = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_ISSUE;
			flush_q    <= FLUSH_RESET;
			cur_q      <= '0;
			seen_q     <= 1'b0;
			pend_q     <= '0;
			len_q      <= '0;
			cat_pend_q <= 1'b0;
		end else begin
			if (cfg_valid) begin
				flush_q <= cfg_data;
			end
			case (state_q)
				ST_ISSUE: begin
					cat_pend_q <= 1'b0;
					if (head_vld && (head.kind inside {CMD_BAD, CMD_END}) && room2) begin
						cur_q  <= '0;
						seen_q <= 1'b0;
						pend_q <= '0;
						len_q  <= '0;
					end else begin
						seen_q <= eff_seen;
						pend_q <= eff_pend;
						if (head_vld && head.kind == CMD_SCAN) begin
							state_q <= ST_EVAL;
						end
					end
				end
				ST_EVAL: begin
					if (trd_q == flush_q) begin
						state_q <= ST_FLUSH;
					end else begin
						cur_q      <= trd_q;
						len_q      <= len_inc;
						cat_pend_q <= 1'b1;
						state_q    <= ST_ISSUE;
					end
				end
				ST_FLUSH: begin
					if (room2) begin
						state_q <= ST_ISSUE;
						seen_q  <= 1'b0;
						pend_q  <= '0;
						if (trd_q == flush_q) begin
							cur_q      <= '0;
							len_q      <= '0;
							cat_pend_q <= 1'b0;
						end else begin
							cur_q      <= trd_q;
							len_q      <= LEN_W'(1);
							cat_pend_q <= 1'b1;
						end
					end
				end
				default: state_q <= ST_ISSUE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (t_re) begin
			trd_q <= tmem_q[t_raddr];
		end
		if (t_we) begin
			tmem_q[t_waddr] <= head.tgt;
		end
	end

	always_ff @(posedge clk) begin
		if (c_re) begin
			crd_q  <= cmem_q[c_raddr];
			chit_q <= cvl_q[c_raddr];
		end
		if (c_we) begin
			cmem_q[c_waddr] <= head.cat;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cvl_q <= '0;
		end else if (c_we) begin
			cvl_q[c_waddr] <= head.cat_ok;
		end
	end

endmodule

// ===== design/tdl_rq.sv =====
// Result queue of the lexer: takes up to two results a cycle from the
// back end, hands out one at a time. Depends on tdl_pkg.
module tdl_rq
	import tdl_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  res_push_t rpush,
	output logic      room2,
	output logic      empty,
	input  logic      pop,
	output result_t   result
);

	localparam int PW = $clog2(RQ_DEPTH);

	result_t       mem_q [RQ_DEPTH];
	logic [PW-1:0] wr_q;
	logic [PW-1:0] rd_q;
	logic [PW:0]   cnt_q;
	logic          do_pop;

	assign empty  = (cnt_q == '0);
	assign room2  = (cnt_q <= (PW+1)'(RQ_DEPTH - 2));
	assign result = mem_q[rd_q];
	assign do_pop = pop && !empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			wr_q  <= wr_q + PW'(rpush.n);
			if (do_pop) begin
				rd_q <= rd_q + PW'(1);
			end
			cnt_q <= cnt_q + (PW+1)'(rpush.n) - (PW+1)'(do_pop);
		end
	end

	always_ff @(posedge clk) begin
		if (rpush.n != 2'd0) begin
			mem_q[wr_q] <= rpush.r0;
		end
		if (rpush.n == 2'd2) begin
			mem_q[wr_q + PW'(1)] <= rpush.r1;
		end
	end

endmodule

// ===== design/tdl_checker.sv =====
// Port-level checks for the table-driven lexer, bound to the top level.
// Depends on tdl_pkg.
module tdl_checker
	import tdl_pkg::*;
(
	input logic               clk,
	input logic               arst_n,
	input logic               push,
	input logic               full,
	input item_t              item,
	input logic               empty,
	input logic               pop,
	input result_t            result,
	input logic               cfg_valid,
	input logic               cfg_ready,
	input logic [STATE_W-1:0] cfg_data
);

	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(result)))
		else $error("result changed while waiting");

	a_error_shape: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && result.kind == KIND_ERROR) |->
		(result.last && result.token_category == '0
		&& !result.token_has_category && result.lexeme_length == '0))
		else $error("malformed error result");

	a_token_shape: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && result.kind == KIND_TOKEN) |->
		(result.error_byte == '0
		&& (result.token_has_category || result.token_category == '0)))
		else $error("malformed token result");

	a_pair_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && !empty && !result.last) |=> !empty)
		else $error("second result of an item missing");

endmodule

bind table_driven_lexer tdl_checker u_chk (.*);
